>>> src/counter_priority_task_scheduler_core_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_CORE_ASSERT_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define CPTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define CPTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/cpts_pkg.sv
// Package with the scheduler's constants, codes and word types.
`timescale 1ns / 1ps
package cpts_pkg;
	localparam int TASK_SLOTS = 64;
	localparam int IDX_W = $clog2(TASK_SLOTS);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_SCHED = 2'd2;

	localparam logic [2:0] RS_RUNNING = 3'd0;
	localparam logic [2:0] RS_INTERRUPTIBLE = 3'd1;

	localparam logic [31:0] SIG_ALARM_BIT = 32'h0000_2000;
	localparam logic [31:0] UNBLOCKABLE = 32'h0004_0100;
	localparam logic [7:0] SLICE_MAX = 8'd127;
	localparam logic signed [7:0] BEST_NONE = -8'sd1;

	typedef struct packed {
		logic [1:0] op;
		logic [5:0] task_index;
		logic present;
		logic [2:0] run_state;
		logic [6:0] time_slice;
		logic [5:0] prio;
		logic [31:0] wake_deadline;
		logic [31:0] alarm_deadline;
		logic [31:0] pending_signals;
		logic [31:0] blocked_signals;
		logic [31:0] now_ticks;
	} cpts_req_t;

	typedef struct packed {
		logic [5:0] next_task;
		logic signed [7:0] best_slice;
		logic rd_present;
		logic [2:0] rd_run_state;
		logic [6:0] rd_slice;
		logic [31:0] rd_signals;
		logic [31:0] rd_wake_deadline;
		logic [31:0] rd_alarm_deadline;
	} cpts_rsp_t;

	typedef struct packed {
		logic [2:0] state;
		logic [6:0] slice;
		logic [5:0] prio;
		logic [31:0] timeout;
		logic [31:0] alarm;
		logic [31:0] pending;
		logic [31:0] blocked;
	} cpts_entry_t;
endpackage

>>> src/cpts_req_if.sv
// Request channel interface carrying one scheduler request word.
`timescale 1ns / 1ps
interface cpts_req_if import cpts_pkg::*; ();
	logic valid;
	logic ready;
	cpts_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/cpts_rsp_if.sv
// Response channel interface carrying one scheduler result word.
`timescale 1ns / 1ps
interface cpts_rsp_if import cpts_pkg::*; ();
	logic valid;
	logic ready;
	cpts_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/cpts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cpts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> src/counter_priority_task_scheduler_core.sv
// Top level of the counter-decay priority task scheduler.
//
// Channel   Dir  Word        Accepted when
// req       in   cpts_req_t  req.valid && req.ready
// rsp       out  cpts_rsp_t  rsp.valid && rsp.ready
//
// A read passes through S_READ before it answers. A schedule walks slots 1 to TASK_SLOTS-1
// through the table RAM's single read port, one slot a cycle: one pass for wake and
// selection, and a second for refill and reselection when the best counter is zero.
// Reset clears only the control state and the slot valid bits.
// Requests are taken only when idle and the result register is free or being emptied.
`timescale 1ns / 1ps
module counter_priority_task_scheduler_core
	import cpts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	cpts_req_if.sink req,
	cpts_rsp_if.source rsp
);
	`include "counter_priority_task_scheduler_core_assert.svh"

	typedef enum logic [1:0] {S_IDLE, S_READ, S_WAKE, S_REFILL} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
	localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

	state_t state_q;
	logic [TASK_SLOTS-1:0] valid_q;
	logic [IDX_W-1:0] cnt_q;
	logic iss_q;
	logic v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic signed [7:0] best_q;
	logic [IDX_W-1:0] pick_q;
	logic [31:0] now_q;
	logic rsp_valid_q;
	cpts_rsp_t rsp_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	cpts_entry_t ram_wdata;
	cpts_entry_t ent;
	cpts_entry_t upd;
	cpts_entry_t wr_ent;
	logic ent_vld;
	logic accept;
	logic idx_ok;
	logic [IDX_W-1:0] req_idx;
	logic to_hit;
	logic al_hit;
	logic [31:0] pend_nx;
	logic [7:0] refill_sum;
	logic take;
	logic pass_last;
	logic signed [7:0] best_nx;
	logic [IDX_W-1:0] pick_nx;
	cpts_rsp_t done_rsp;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;
	assign req_idx = IDX_W'(req.data.task_index);
	assign idx_ok = 32'(req.data.task_index) < 32'(TASK_SLOTS);
	assign ent_vld = valid_q[idx_s1];

	always_comb begin
		wr_ent = '0;
		wr_ent.state = req.data.run_state;
		wr_ent.slice = req.data.time_slice;
		wr_ent.prio = (req.data.prio == 6'd0) ? 6'd1 : req.data.prio;
		wr_ent.timeout = req.data.wake_deadline;
		wr_ent.alarm = req.data.alarm_deadline;
		wr_ent.pending = req.data.pending_signals;
		wr_ent.blocked = req.data.blocked_signals;
	end

	always_comb begin
		upd = ent;
		to_hit = (ent.timeout != 32'd0) && (ent.timeout < now_q);
		al_hit = (ent.alarm != 32'd0) && (ent.alarm < now_q);
		pend_nx = ent.pending | (al_hit ? SIG_ALARM_BIT : 32'd0);
		refill_sum = 8'(ent.slice >> 1) + 8'(ent.prio);
		if (state_q == S_REFILL) begin
			upd.slice = (refill_sum > SLICE_MAX) ? 7'(SLICE_MAX) : refill_sum[6:0];
		end else begin
			if (to_hit) begin
				upd.timeout = 32'd0;
				if (ent.state == RS_INTERRUPTIBLE) begin
					upd.state = RS_RUNNING;
				end
			end
			if (al_hit) begin
				upd.alarm = 32'd0;
			end
			upd.pending = pend_nx;
			if (((pend_nx & ~(ent.blocked & ~UNBLOCKABLE)) != 32'd0)
					&& (upd.state == RS_INTERRUPTIBLE)) begin
				upd.state = RS_RUNNING;
			end
		end
		take = v_s1 && ent_vld && (upd.state == RS_RUNNING)
			&& ($signed({1'b0, upd.slice}) >= best_q);
		best_nx = take ? $signed({1'b0, upd.slice}) : best_q;
		pick_nx = take ? idx_s1 : pick_q;
		pass_last = v_s1 && (idx_s1 == LAST_IDX);
		done_rsp = '0;
		done_rsp.next_task = 6'(pick_nx);
		done_rsp.best_slice = best_nx;
	end

	always_comb begin
		if (state_q == S_IDLE) begin
			ram_raddr = req_idx;
			ram_waddr = req_idx;
			ram_wdata = wr_ent;
			ram_we = accept && (req.data.op == OP_WRITE) && idx_ok;
		end else begin
			ram_raddr = cnt_q;
			ram_waddr = idx_s1;
			ram_wdata = upd;
			ram_we = v_s1 && ent_vld;
		end
	end

	cpts_ram #(
		.WIDTH($bits(cpts_entry_t)),
		.DEPTH(TASK_SLOTS)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			cnt_q <= '0;
			iss_q <= 1'b0;
			v_s1 <= 1'b0;
			idx_s1 <= '0;
			best_q <= BEST_NONE;
			pick_q <= '0;
			now_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			v_s1 <= iss_q;
			idx_s1 <= cnt_q;
			if (iss_q) begin
				if (cnt_q == LAST_IDX) begin
					iss_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rsp_q <= '0;
						case (req.data.op)
							OP_WRITE: begin
								if (idx_ok) begin
									valid_q[req_idx] <= req.data.present;
								end
								rsp_valid_q <= 1'b1;
							end
							OP_READ: begin
								pick_q <= req_idx;
								now_q <= {31'd0, idx_ok};
								state_q <= S_READ;
							end
							OP_SCHED: begin
								now_q <= req.data.now_ticks;
								best_q <= BEST_NONE;
								pick_q <= '0;
								cnt_q <= FIRST_IDX;
								iss_q <= 1'b1;
								state_q <= S_WAKE;
							end
							default: begin
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					rsp_q <= '0;
					if (now_q[0]) begin
						rsp_q.rd_present <= valid_q[pick_q];
						rsp_q.rd_run_state <= ent.state;
						rsp_q.rd_slice <= ent.slice;
						rsp_q.rd_signals <= ent.pending;
						rsp_q.rd_wake_deadline <= ent.timeout;
						rsp_q.rd_alarm_deadline <= ent.alarm;
					end
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_WAKE, S_REFILL: begin
					best_q <= best_nx;
					pick_q <= pick_nx;
					if (pass_last) begin
						if ((state_q == S_WAKE) && (best_nx == 8'sd0)) begin
							best_q <= BEST_NONE;
							pick_q <= '0;
							cnt_q <= FIRST_IDX;
							iss_q <= 1'b1;
							state_q <= S_REFILL;
						end else begin
							rsp_q <= done_rsp;
							rsp_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	`CPTS_ASSERT_NOW(a_busy_not_ready, state_q != S_IDLE, !req.ready, "ready while busy")
	`CPTS_ASSERT_NOW(a_no_idle_slot, v_s1, idx_s1 != '0, "slot zero walked")
	`CPTS_ASSERT_NEXT(a_refill_nonzero, (state_q == S_REFILL) && pass_last,
		rsp.valid && (rsp.data.best_slice != 8'sd0), "zero counter after refill")
	`CPTS_ASSERT_NOW(a_walk_only_in_pass, v_s1,
		(state_q == S_WAKE) || (state_q == S_REFILL), "walk outside a pass")
endmodule

>>> test/tb.sv
// Self-checking testbench for the counter-decay priority task scheduler core.
`timescale 1ns / 1ps
module tb;
	import cpts_pkg::*;

	logic clk;
	logic arst_n;
	cpts_req_if req_if ();
	cpts_rsp_if rsp_if ();

	counter_priority_task_scheduler_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	logic tbl_valid [TASK_SLOTS];
	logic [2:0] tbl_state [TASK_SLOTS];
	logic [6:0] tbl_slice [TASK_SLOTS];
	logic [5:0] tbl_prio [TASK_SLOTS];
	logic [31:0] tbl_timeout [TASK_SLOTS];
	logic [31:0] tbl_alarm [TASK_SLOTS];
	logic [31:0] tbl_pending [TASK_SLOTS];
	logic [31:0] tbl_blocked [TASK_SLOTS];
	bit slot_written [TASK_SLOTS];

	cpts_rsp_t expected_words[$];
	int errors;
	int send_idle_pct;
	int rsp_stall_pct;
	int hold_req;
	bit hold_active;
	logic [31:0] tick_now;

	always #4 clk = ~clk;

	function automatic int pick_runnable(output logic [5:0] pick);
		int best;
		best = -1;
		pick = '0;
		for (int k = TASK_SLOTS - 1; k >= 1; k--) begin
			if (tbl_valid[k] && tbl_state[k] == RS_RUNNING && int'(tbl_slice[k]) > best) begin
				best = int'(tbl_slice[k]);
				pick = k[5:0];
			end
		end
		return best;
	endfunction

	function automatic cpts_rsp_t predict_word(cpts_req_t w);
		cpts_rsp_t r;
		int best;
		int v;
		logic [5:0] pick;
		r = '0;
		case (w.op)
			OP_WRITE: begin
				tbl_valid[w.task_index] = w.present;
				tbl_state[w.task_index] = w.run_state;
				tbl_slice[w.task_index] = w.time_slice;
				tbl_prio[w.task_index] = (w.prio == 0) ? 6'd1 : w.prio;
				tbl_timeout[w.task_index] = w.wake_deadline;
				tbl_alarm[w.task_index] = w.alarm_deadline;
				tbl_pending[w.task_index] = w.pending_signals;
				tbl_blocked[w.task_index] = w.blocked_signals;
				slot_written[w.task_index] = 1'b1;
			end
			OP_READ: begin
				r.rd_present = tbl_valid[w.task_index];
				r.rd_run_state = tbl_state[w.task_index];
				r.rd_slice = tbl_slice[w.task_index];
				r.rd_signals = tbl_pending[w.task_index];
				r.rd_wake_deadline = tbl_timeout[w.task_index];
				r.rd_alarm_deadline = tbl_alarm[w.task_index];
			end
			OP_SCHED: begin
				for (int k = 1; k < TASK_SLOTS; k++) begin
					if (tbl_valid[k]) begin
						if (tbl_timeout[k] != 0 && tbl_timeout[k] < w.now_ticks) begin
							tbl_timeout[k] = '0;
							if (tbl_state[k] == RS_INTERRUPTIBLE)
								tbl_state[k] = RS_RUNNING;
						end
						if (tbl_alarm[k] != 0 && tbl_alarm[k] < w.now_ticks) begin
							tbl_pending[k] |= SIG_ALARM_BIT;
							tbl_alarm[k] = '0;
						end
						if ((tbl_pending[k] & ~(tbl_blocked[k] & ~UNBLOCKABLE)) != 0
								&& tbl_state[k] == RS_INTERRUPTIBLE)
							tbl_state[k] = RS_RUNNING;
					end
				end
				best = pick_runnable(pick);
				if (best == 0) begin
					for (int k = 1; k < TASK_SLOTS; k++) begin
						if (tbl_valid[k]) begin
							v = int'(tbl_slice[k] >> 1) + int'(tbl_prio[k]);
							tbl_slice[k] = (v > 127) ? 7'd127 : v[6:0];
						end
					end
					best = pick_runnable(pick);
				end
				r.next_task = pick;
				r.best_slice = best[7:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_word(cpts_req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= w;
		do @(posedge clk); while (!req_if.ready);
		expected_words.push_back(predict_word(w));
	endtask

	task automatic wait_drain();
		req_if.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic cpts_req_t write_word(int idx, logic pres, logic [2:0] st,
			logic [6:0] sl, logic [5:0] pr, logic [31:0] tmo, logic [31:0] alm,
			logic [31:0] pend, logic [31:0] blk);
		cpts_req_t w;
		w = '0;
		w.op = OP_WRITE;
		w.task_index = idx[5:0];
		w.present = pres;
		w.run_state = st;
		w.time_slice = sl;
		w.prio = pr;
		w.wake_deadline = tmo;
		w.alarm_deadline = alm;
		w.pending_signals = pend;
		w.blocked_signals = blk;
		return w;
	endfunction

	function automatic cpts_req_t read_word(int idx);
		cpts_req_t w;
		w = '0;
		w.op = OP_READ;
		w.task_index = idx[5:0];
		return w;
	endfunction

	function automatic cpts_req_t sched_word(logic [31:0] now);
		cpts_req_t w;
		w = '0;
		w.op = OP_SCHED;
		w.now_ticks = now;
		return w;
	endfunction

	function automatic logic [31:0] random_deadline();
		case ($urandom_range(3))
			0: return '0;
			1: return $urandom;
			default: return tick_now + $urandom_range(60) - 30;
		endcase
	endfunction

	function automatic cpts_req_t random_word();
		cpts_req_t w;
		int sel;
		int idx;
		logic [191:0] raw;
		w = '0;
		w.now_ticks = $urandom;
		sel = $urandom_range(99);
		if (sel < 25) begin
			idx = $urandom_range(TASK_SLOTS - 1);
			while (!slot_written[idx])
				idx = $urandom_range(TASK_SLOTS - 1);
			w = read_word(idx);
		end else if (sel < 60) begin
			tick_now = ($urandom_range(19) == 0) ? $urandom : tick_now + $urandom_range(25);
			w = sched_word(tick_now);
		end else if (sel < 64) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			w = raw[$bits(cpts_req_t)-1:0];
			w.op = 2'd3;
		end else begin
			w = write_word($urandom_range(TASK_SLOTS - 1), $urandom_range(99) < 85,
				($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1)),
				($urandom_range(2) == 0) ? 7'd0 : 7'($urandom_range(127)),
				6'($urandom_range(63)), random_deadline(), random_deadline(),
				($urandom_range(2) == 0) ? 32'd0 : $urandom & $urandom,
				($urandom_range(1) == 0) ? $urandom : ~32'd0);
			w.now_ticks = $urandom;
		end
		return w;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cpts_rsp_t got;
		cpts_rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 32'(got.next_task), '0);
			end else begin
				want = expected_words.pop_front();
				if (got.next_task !== want.next_task)
					report_mismatch("next_task", 32'(got.next_task), 32'(want.next_task));
				if (got.best_slice !== want.best_slice)
					report_mismatch("best_slice", 32'(got.best_slice),
						32'(want.best_slice));
				if (got.rd_present !== want.rd_present)
					report_mismatch("rd_present", 32'(got.rd_present),
						32'(want.rd_present));
				if (got.rd_run_state !== want.rd_run_state)
					report_mismatch("rd_run_state", 32'(got.rd_run_state),
						32'(want.rd_run_state));
				if (got.rd_slice !== want.rd_slice)
					report_mismatch("rd_slice", 32'(got.rd_slice), 32'(want.rd_slice));
				if (got.rd_signals !== want.rd_signals)
					report_mismatch("rd_signals", got.rd_signals, want.rd_signals);
				if (got.rd_wake_deadline !== want.rd_wake_deadline)
					report_mismatch("rd_wake_deadline", got.rd_wake_deadline,
						want.rd_wake_deadline);
				if (got.rd_alarm_deadline !== want.rd_alarm_deadline)
					report_mismatch("rd_alarm_deadline", got.rd_alarm_deadline,
						want.rd_alarm_deadline);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			rsp_if.ready <= 1'b0;
		else
			rsp_if.ready <= !hold_active && ($urandom_range(99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_active = 1'b1;
			repeat (hold_req) @(posedge clk);
			hold_req = 0;
			hold_active = 1'b0;
		end
	end

	task automatic test_idle_table();
		send_word(sched_word(32'd0));
		send_word(sched_word(32'hFFFF_FFFF));
	endtask

	task automatic test_table_access();
		cpts_req_t w;
		send_word(write_word(0, 1'b1, RS_RUNNING, 7'd127, 6'd63, '1, '1, '1, '1));
		send_word(write_word(63, 1'b1, 3'd7, 7'd127, 6'd0, 32'h8000_0001,
			32'h5555_5555, 32'hAAAA_AAAA, '0));
		send_word(write_word(5, 1'b0, 3'd5, 7'd0, 6'd63, '0, '0, '0, '0));
		send_word(read_word(0));
		send_word(read_word(63));
		send_word(read_word(5));
		w = '1;
		w.op = 2'd3;
		send_word(w);
	endtask

	task automatic test_wakeups();
		send_word(write_word(1, 1'b1, RS_INTERRUPTIBLE, 7'd20, 6'd3, 32'd100, '0, '0, '0));
		send_word(sched_word(32'd100));
		send_word(sched_word(32'd101));
		send_word(write_word(2, 1'b1, RS_INTERRUPTIBLE, 7'd40, 6'd3, '0, 32'd50, '0, '1));
		send_word(sched_word(32'd60));
		send_word(read_word(2));
		send_word(write_word(3, 1'b1, RS_INTERRUPTIBLE, 7'd50, 6'd3, '0, '0,
			32'h0000_0100, '1));
		send_word(write_word(4, 1'b1, RS_INTERRUPTIBLE, 7'd60, 6'd3, '0, '0,
			32'h0004_0000, '1));
		send_word(write_word(6, 1'b1, RS_INTERRUPTIBLE, 7'd70, 6'd3, '0, '0,
			32'h0000_0004, 32'h0000_0004));
		send_word(write_word(7, 1'b1, 3'd2, 7'd80, 6'd3, 32'd1, '0, '1, '0));
		send_word(sched_word(32'd200));
		send_word(read_word(7));
	endtask

	task automatic test_refill();
		for (int k = 1; k < 8; k++)
			send_word(write_word(k, 1'b1, RS_RUNNING, (k == 3) ? 7'd127 : 7'd0,
				(k == 5) ? 6'd63 : 6'd0, '0, '0, '0, '0));
		send_word(sched_word(32'd300));
		send_word(write_word(3, 1'b1, RS_RUNNING, 7'd0, 6'd63, '0, '0, '0, '0));
		send_word(sched_word(32'd301));
		send_word(read_word(3));
	endtask

	task automatic test_random_phase(int idle, int stall, int count);
		send_idle_pct = idle;
		rsp_stall_pct = stall;
		for (int i = 0; i < count; i++)
			send_word(random_word());
		wait_drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_req = 400;
		for (int i = 0; i < 12; i++)
			send_word(($urandom_range(1) == 0) ? sched_word(tick_now) : read_word(1));
		wait_drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		errors = 0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_req = 0;
		hold_active = 1'b0;
		tick_now = 32'd1000;
		for (int k = 0; k < TASK_SLOTS; k++) begin
			tbl_valid[k] = 1'b0;
			slot_written[k] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_table();
		test_table_access();
		test_wakeups();
		test_refill();
		wait_drain();
		test_random_phase(0, 0, 300);
		test_random_phase(45, 0, 300);
		test_backpressure();
		test_random_phase(0, 45, 300);
		test_random_phase(34, 34, 300);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("counter_priority_task_scheduler_core verification clean");
		else
			$display("counter_priority_task_scheduler_core verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("counter_priority_task_scheduler_core verification failed");
		$finish;
	end
endmodule
